### rtl/cpfm_pkg.sv
// shared types and constants of the capture period frequency meter
// no dependencies
package cpfm_pkg;

  localparam int unsigned CaptureWidth = 16;
  localparam int unsigned PeriodWidth  = 32;
  localparam int unsigned ClockWidth   = 26;
  localparam int unsigned DataWidth    = 32;
  localparam int unsigned AddrWidth    = 3;
  localparam int unsigned QueueDepth   = 2;
  localparam int unsigned TimerBitsDefault = 16;

  localparam logic [ClockWidth-1:0]   ClockHzReset = 26'd22118400;
  localparam logic [CaptureWidth-1:0] OvfLimit     = 16'hFFFF;
  localparam logic [PeriodWidth-1:0]  PreScale     = 32'd50;
  localparam logic [PeriodWidth+4:0]  PostScale    = 37'd20;

  localparam logic [AddrWidth-3:0] RegClockHz = 1'b0;

  typedef struct packed {
    logic                    overflow_event;
    logic                    capture_event;
    logic [CaptureWidth-1:0] cap_count;
  } in_item_t;

  typedef struct packed {
    logic [PeriodWidth-1:0] period_ticks;
    logic [PeriodWidth-1:0] frequency_mhz;
    logic                   captured;
  } out_item_t;

  typedef struct packed {
    logic [PeriodWidth-1:0] period;
    logic                   captured;
  } job_t;

  typedef enum logic [1:0] {
    BkIdle,
    BkDiv,
    BkDone
  } bk_state_e;

endpackage

### rtl/cpfm_front.sv
// front end: accepts events, tracks overflows and captures, forms the period
// depends on cpfm_pkg
module cpfm_front #(
  parameter int unsigned TIMER_BITS = cpfm_pkg::TimerBitsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  cpfm_pkg::in_item_t in_item_i,
  input  logic               q_full_i,
  output logic               q_push_o,
  output cpfm_pkg::job_t     q_job_o
);

  localparam logic [cpfm_pkg::CaptureWidth-1:0] CapMask =
    (TIMER_BITS >= cpfm_pkg::CaptureWidth) ? {cpfm_pkg::CaptureWidth{1'b1}} :
    cpfm_pkg::CaptureWidth'((64'd1 << TIMER_BITS) - 64'd1);

  logic [cpfm_pkg::CaptureWidth-1:0] ovf_cnt_q, ovf_cnt_d;
  logic [cpfm_pkg::CaptureWidth-1:0] last_cap_q, last_cap_d;
  logic [cpfm_pkg::PeriodWidth-1:0]  period_q, period_d;
  logic [cpfm_pkg::CaptureWidth-1:0] cnt_inc, cnt_mid, cval;
  logic [cpfm_pkg::PeriodWidth-1:0]  per_mid, per_new;
  logic                              push;

  assign push       = in_valid_i && !q_full_i;
  assign in_stall_o = q_full_i;
  assign q_push_o   = push;

  assign cnt_inc = ovf_cnt_q + 1'b1;
  assign cval    = in_item_i.cap_count & CapMask;

  always_comb begin
    cnt_mid = ovf_cnt_q;
    per_mid = period_q;
    if (in_item_i.overflow_event) begin
      if (cnt_inc == cpfm_pkg::OvfLimit) begin
        cnt_mid = cpfm_pkg::OvfLimit - 1'b1;
        per_mid = '0;
      end else begin
        cnt_mid = cnt_inc;
      end
    end
    per_new    = (cpfm_pkg::PeriodWidth'(cnt_mid) << TIMER_BITS)
               + cpfm_pkg::PeriodWidth'(cval)
               - cpfm_pkg::PeriodWidth'(last_cap_q);
    ovf_cnt_d  = cnt_mid;
    period_d   = per_mid;
    last_cap_d = last_cap_q;
    if (in_item_i.capture_event) begin
      ovf_cnt_d  = '0;
      period_d   = per_new;
      last_cap_d = cval;
    end
  end

  assign q_job_o.period   = period_d;
  assign q_job_o.captured = in_item_i.capture_event;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovf_cnt_q  <= '0;
      last_cap_q <= '0;
      period_q   <= '0;
    end else if (push) begin
      ovf_cnt_q  <= ovf_cnt_d;
      last_cap_q <= last_cap_d;
      period_q   <= period_d;
    end
  end

endmodule

### rtl/cpfm_queue.sv
// short job queue between the front end and the divider back end
// depends on cpfm_pkg
module cpfm_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  cpfm_pkg::job_t job_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output cpfm_pkg::job_t job_o
);

  localparam int unsigned PtrWidth = $clog2(cpfm_pkg::QueueDepth);

  cpfm_pkg::job_t              mem_q [cpfm_pkg::QueueDepth];
  logic [PtrWidth-1:0]         wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [PtrWidth:0]           count_q, count_d;

  assign full_o  = (count_q == (PtrWidth+1)'(cpfm_pkg::QueueDepth));
  assign empty_o = (count_q == '0);
  assign job_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrWidth'(cpfm_pkg::QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrWidth'(cpfm_pkg::QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

### rtl/cpfm_back.sv
// back end: bit-serial divider for the frequency and the result register
// depends on cpfm_pkg
module cpfm_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [cpfm_pkg::ClockWidth-1:0]     clock_hz_i,
  input  logic                                q_empty_i,
  input  cpfm_pkg::job_t                      q_job_i,
  output logic                                q_pop_o,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output cpfm_pkg::out_item_t                 out_item_o
);

  localparam int unsigned W = cpfm_pkg::PeriodWidth;
  localparam int unsigned CntWidth = $clog2(W);

  cpfm_pkg::bk_state_e state_q, state_d;

  logic [W-1:0]        rem_q, rem_d, quo_q, quo_d, div_q;
  logic                cap_q;
  logic [CntWidth-1:0] cnt_q, cnt_d;
  logic [W:0]          shifted;
  logic                ge;
  logic [W+4:0]        prod;
  logic [W-1:0]        freq;
  logic                out_free, load, step, out_load;

  cpfm_pkg::out_item_t out_item_q;
  logic                out_valid_q;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      cpfm_pkg::BkIdle: begin
        if (!q_empty_i) begin
          state_d = cpfm_pkg::BkDiv;
        end
      end
      cpfm_pkg::BkDiv: begin
        if (cnt_q == CntWidth'(W - 1)) begin
          state_d = cpfm_pkg::BkDone;
        end
      end
      cpfm_pkg::BkDone: begin
        if (out_free) begin
          state_d = cpfm_pkg::BkIdle;
        end
      end
      default: state_d = cpfm_pkg::BkIdle;
    endcase
  end

  always_comb begin
    load     = 1'b0;
    step     = 1'b0;
    out_load = 1'b0;
    case (state_q)
      cpfm_pkg::BkIdle: load     = !q_empty_i;
      cpfm_pkg::BkDiv:  step     = 1'b1;
      cpfm_pkg::BkDone: out_load = out_free;
      default: ;
    endcase
  end

  assign q_pop_o = load;

  assign shifted = {rem_q, quo_q[W-1]};
  assign ge      = (shifted >= {1'b0, div_q});

  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    cnt_d = cnt_q;
    if (load) begin
      rem_d = '0;
      quo_d = W'(clock_hz_i) * cpfm_pkg::PreScale;
      cnt_d = '0;
    end else if (step) begin
      rem_d = ge ? W'(shifted - {1'b0, div_q}) : W'(shifted);
      quo_d = {quo_q[W-2:0], ge};
      cnt_d = cnt_q + 1'b1;
    end
  end

  assign prod = (W+5)'(quo_q) * cpfm_pkg::PostScale;
  always_comb begin
    if (div_q == '0) begin
      freq = '0;
    end else if (prod[W+4:W] != '0) begin
      freq = '1;
    end else begin
      freq = prod[W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cpfm_pkg::BkIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (load) begin
      div_q <= q_job_i.period;
      cap_q <= q_job_i.captured;
    end
    if (out_load) begin
      out_item_q.period_ticks  <= div_q;
      out_item_q.frequency_mhz <= freq;
      out_item_q.captured      <= cap_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

### rtl/capture_period_frequency_meter.sv
// capture period frequency meter: reciprocal frequency from timer captures
// the back end takes a new job only after its 32-step bit-serial divider is done
// a two-entry queue lets the front take events while the divider runs
// reset: clock_hz to 22118400, overflow count, last capture and period to 0
// depends on cpfm_pkg, cpfm_front, cpfm_queue, cpfm_back
module capture_period_frequency_meter #(
  parameter int unsigned TIMER_BITS = cpfm_pkg::TimerBitsDefault
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  cpfm_pkg::in_item_t                 in_item_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output cpfm_pkg::out_item_t                out_item_o,
  input  logic                               psel_i,
  input  logic                               penable_i,
  input  logic                               pwrite_i,
  input  logic [cpfm_pkg::AddrWidth-1:0]     paddr_i,
  input  logic [cpfm_pkg::DataWidth-1:0]     pwdata_i,
  output logic [cpfm_pkg::DataWidth-1:0]     prdata_o,
  output logic                               pready_o
);

  logic [cpfm_pkg::ClockWidth-1:0] clock_hz_q;
  logic                            cfg_sel;
  logic                            q_full, q_empty, q_push, q_pop;
  cpfm_pkg::job_t                  q_job_in, q_job_out;

  assign pready_o = 1'b1;
  assign cfg_sel  = (paddr_i[cpfm_pkg::AddrWidth-1:2] == cpfm_pkg::RegClockHz);
  assign prdata_o = cfg_sel ? cpfm_pkg::DataWidth'(clock_hz_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clock_hz_q <= cpfm_pkg::ClockHzReset;
    end else if (psel_i && penable_i && pwrite_i && cfg_sel) begin
      clock_hz_q <= pwdata_i[cpfm_pkg::ClockWidth-1:0];
    end
  end

  cpfm_front #(
    .TIMER_BITS(TIMER_BITS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_item_i (in_item_i),
    .q_full_i  (q_full),
    .q_push_o  (q_push),
    .q_job_o   (q_job_in)
  );

  cpfm_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .job_i  (q_job_in),
    .full_o (q_full),
    .pop_i  (q_pop),
    .empty_o(q_empty),
    .job_o  (q_job_out)
  );

  cpfm_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clock_hz_i (clock_hz_q),
    .q_empty_i  (q_empty),
    .q_job_i    (q_job_out),
    .q_pop_o    (q_pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

endmodule
